// ----- sv/ssfs_pkg.sv -----
// Shared types, constants and segment encoding for the seven-segment frame shifter.
package ssfs_pkg;

    localparam logic CMD_REFRESH = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    localparam logic [1:0] PH_CLK_RISE = 2'd0;
    localparam logic [1:0] PH_CLK_FALL = 2'd1;
    localparam logic [1:0] PH_STB_RISE = 2'd2;
    localparam logic [1:0] PH_STB_FALL = 2'd3;

    localparam logic [7:0] SEG_BLANK       = 8'hFF;
    localparam logic [7:0] LED_GROUP_OFF   = 8'hFF;
    localparam logic [7:0] SINGLE_LEDS_OFF = 8'h71;
    localparam logic [7:0] DOT_CLEAR_MASK  = 8'h7F;

    localparam int VALUE_W = 17;

    // frame byte positions
    localparam logic [3:0] BYTE_LUX_LAST  = 4'd0;
    localparam logic [3:0] BYTE_LUX_LEAD  = 4'd1;
    localparam logic [3:0] BYTE_LUX_MID   = 4'd2;
    localparam logic [3:0] BYTE_LED_GRP_A = 4'd3;
    localparam logic [3:0] BYTE_SINGLE    = 4'd4;
    localparam logic [3:0] BYTE_VOLT_LAST = 4'd5;
    localparam logic [3:0] BYTE_VOLT_LEAD = 4'd6;
    localparam logic [3:0] BYTE_VOLT_MID  = 4'd7;
    localparam logic [3:0] BYTE_LED_GRP_B = 4'd8;
    localparam logic [3:0] BYTE_FIRST     = BYTE_LED_GRP_B;

    localparam logic [2:0] BIT_FIRST = 3'd0;
    localparam logic [2:0] BIT_LAST  = 3'd7;

    // floor(v / 1000) = (v * RECIP_1000) >> RECIP_SHIFT for v < 2^17
    localparam logic [17:0] RECIP_1000  = 18'd134218;
    localparam int          RECIP_SHIFT = 27;

    typedef struct packed {
        logic [7:0] lead;
        logic [7:0] mid;
        logic [7:0] last;
    } seg_triplet_t;

    typedef struct packed {
        logic data_pin;
        logic clock_pin;
        logic strobe_pin;
        logic frame_done;
        logic busy_res;
        logic refresh_ignored;
    } result_t;

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = 8'h88;
            4'd1:    code = 8'hEE;
            4'd2:    code = 8'h94;
            4'd3:    code = 8'hC4;
            4'd4:    code = 8'hE2;
            4'd5:    code = 8'hC1;
            4'd6:    code = 8'h81;
            4'd7:    code = 8'hEC;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'hC0;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

// ----- sv/seven_segment_frame_shifter_top.sv -----
// Seven-segment frame shifter: refresh and tick items in, pin levels out.
//
// Input channel (in_valid/in_stall): command 0 renders voltage_mv and
// lux_value into the nine-byte frame and starts sending it unless busy;
// command 1 is a timer tick that advances the serial pins by one phase.
// Output channel (out_valid/out_stall): one beat per input beat with the
// pin levels and flags after that item.
// A result beat is registered in the output queue before it is offered.
// Throughput: one item per cycle while in_stall is low; the sequencer
// resolves each item combinationally and results queue in a two-entry buffer.
// Digit bytes are written from converter codes after an accepted refresh, well
// before the shifter reaches them (the first byte out is a fixed LED byte).
// Receiver stall: results hold in the buffer; in_stall rises only when
// both entries are full.
// Reset: buffer empty, pins low, frame blank, and the blank frame is
// pending, so busy_res reads 1 until it has been shifted out.
module seven_segment_frame_shifter_top
    import ssfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [16:0] voltage_mv,
    input  logic [15:0] lux_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        data_pin,
    output logic        clock_pin,
    output logic        strobe_pin,
    output logic        frame_done,
    output logic        busy_res,
    output logic        refresh_ignored
);

    logic         accept;
    logic         conv_start;
    logic         volt_valid;
    logic         lux_valid;
    seg_triplet_t volt_codes;
    seg_triplet_t lux_codes;
    result_t      result;
    result_t      head;
    logic         full;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    ssfs_digits u_volt_digits (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (conv_start),
        .value       (voltage_mv),
        .codes_valid (volt_valid),
        .codes       (volt_codes)
    );

    ssfs_digits u_lux_digits (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (conv_start),
        .value       ({1'b0, lux_value}),
        .codes_valid (lux_valid),
        .codes       (lux_codes)
    );

    ssfs_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .command     (command),
        .codes_valid (volt_valid && lux_valid),
        .volt_codes  (volt_codes),
        .lux_codes   (lux_codes),
        .conv_start  (conv_start),
        .result      (result)
    );

    ssfs_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (result),
        .pop        (out_valid && !out_stall),
        .full       (full),
        .head_valid (out_valid),
        .head       (head)
    );

    assign data_pin        = head.data_pin;
    assign clock_pin       = head.clock_pin;
    assign strobe_pin      = head.strobe_pin;
    assign frame_done      = head.frame_done;
    assign busy_res        = head.busy_res;
    assign refresh_ignored = head.refresh_ignored;

endmodule

// ----- sv/ssfs_digits.sv -----
// Four-stage value to three-digit segment code converter.
module ssfs_digits
    import ssfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] value,
    output logic               codes_valid,
    output seg_triplet_t       codes
);

    logic [34:0]        prod_1000;
    logic [7:0]         whole_s1_reg;
    logic [VALUE_W-1:0] value_s1_reg;
    logic               v1_reg;

    logic [16:0] rest_full;
    logic [9:0]  rest_s2_reg;
    logic [7:0]  whole_s2_reg;
    logic        v2_reg;

    logic [17:0] q10_prod;
    logic [15:0] h_prod;
    logic [15:0] wq_prod;
    logic [6:0]  q10_s3_reg;
    logic [3:0]  h_s3_reg;
    logic [4:0]  wq_s3_reg;
    logic [9:0]  rest_s3_reg;
    logic [7:0]  whole_s3_reg;
    logic        v3_reg;

    logic [9:0]   u_full;
    logic [6:0]   t_full;
    logic [7:0]   wu_full;
    logic [4:0]   wt_full;
    seg_triplet_t codes_next;
    seg_triplet_t codes_reg;
    logic         v4_reg;

    assign prod_1000 = 35'(value) * 35'(RECIP_1000);
    assign rest_full = value_s1_reg - 17'(whole_s1_reg) * 17'd1000;
    assign q10_prod  = 18'(rest_s2_reg) * 18'd205;
    assign h_prod    = 16'(rest_s2_reg) * 16'd41;
    assign wq_prod   = 16'(whole_s2_reg) * 16'd205;

    assign u_full  = rest_s3_reg - 10'(q10_s3_reg) * 10'd10;
    assign t_full  = q10_s3_reg - 7'(h_s3_reg) * 7'd10;
    assign wu_full = whole_s3_reg - 8'(wq_s3_reg) * 8'd10;
    assign wt_full = (wq_s3_reg >= 5'd10) ? wq_s3_reg - 5'd10 : wq_s3_reg;

    always_comb
    begin
        if (whole_s3_reg == 8'd0)
        begin
            codes_next.last = seg_code(u_full[3:0]);
            codes_next.mid  = (rest_s3_reg >= 10'd10) ? seg_code(t_full[3:0]) : SEG_BLANK;
            codes_next.lead = (rest_s3_reg >= 10'd100) ? seg_code(h_s3_reg) : SEG_BLANK;
        end
        else
        begin
            codes_next.last = seg_code(h_s3_reg);
            codes_next.mid  = seg_code(wu_full[3:0]) & DOT_CLEAR_MASK;
            codes_next.lead = (wq_s3_reg != 5'd0) ? seg_code(wt_full[3:0]) : SEG_BLANK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_s1_reg <= value;
        whole_s1_reg <= prod_1000[34:RECIP_SHIFT];
        rest_s2_reg  <= rest_full[9:0];
        whole_s2_reg <= whole_s1_reg;
        q10_s3_reg   <= q10_prod[17:11];
        h_s3_reg     <= h_prod[15:12];
        wq_s3_reg    <= wq_prod[15:11];
        rest_s3_reg  <= rest_s2_reg;
        whole_s3_reg <= whole_s2_reg;
        codes_reg    <= codes_next;
    end

    assign codes_valid = v4_reg;
    assign codes       = codes_reg;

endmodule

// ----- sv/ssfs_seq.sv -----
// Frame store and pin phase sequencer.
module ssfs_seq
    import ssfs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic         command,
    input  logic         codes_valid,
    input  seg_triplet_t volt_codes,
    input  seg_triplet_t lux_codes,
    output logic         conv_start,
    output result_t      result
);

    seg_triplet_t volt_reg;
    seg_triplet_t lux_reg;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [3:0] byte_ptr_reg;
    logic [3:0] byte_ptr_next;
    logic [2:0] bit_ptr_reg;
    logic [2:0] bit_ptr_next;
    logic       sending_reg;
    logic       sending_next;
    logic       data_reg;
    logic       data_next;
    logic       clock_reg;
    logic       clock_next;
    logic       strobe_reg;
    logic       strobe_next;
    logic       done;
    logic       ignored;
    logic [7:0] cur_byte;

    always_comb
    begin
        unique case (byte_ptr_reg)
            BYTE_LUX_LAST:  cur_byte = lux_reg.last;
            BYTE_LUX_LEAD:  cur_byte = lux_reg.lead;
            BYTE_LUX_MID:   cur_byte = lux_reg.mid;
            BYTE_LED_GRP_A: cur_byte = LED_GROUP_OFF;
            BYTE_SINGLE:    cur_byte = SINGLE_LEDS_OFF;
            BYTE_VOLT_LAST: cur_byte = volt_reg.last;
            BYTE_VOLT_LEAD: cur_byte = volt_reg.lead;
            BYTE_VOLT_MID:  cur_byte = volt_reg.mid;
            BYTE_LED_GRP_B: cur_byte = LED_GROUP_OFF;
            default:        cur_byte = lux_reg.last;
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        byte_ptr_next = byte_ptr_reg;
        bit_ptr_next  = bit_ptr_reg;
        sending_next  = sending_reg;
        data_next     = data_reg;
        clock_next    = clock_reg;
        strobe_next   = strobe_reg;
        done          = 1'b0;
        ignored       = 1'b0;
        conv_start    = 1'b0;
        if (accept)
        begin
            if (command == CMD_REFRESH)
            begin
                if (sending_reg)
                begin
                    ignored = 1'b1;
                end
                else
                begin
                    conv_start    = 1'b1;
                    phase_next    = PH_CLK_RISE;
                    byte_ptr_next = BYTE_FIRST;
                    bit_ptr_next  = BIT_FIRST;
                    sending_next  = 1'b1;
                end
            end
            else if (sending_reg)
            begin
                unique case (phase_reg)
                    PH_CLK_RISE:
                    begin
                        data_next  = cur_byte[bit_ptr_reg];
                        clock_next = 1'b1;
                        phase_next = PH_CLK_FALL;
                    end
                    PH_CLK_FALL:
                    begin
                        clock_next = 1'b0;
                        if (bit_ptr_reg == BIT_LAST)
                        begin
                            bit_ptr_next = BIT_FIRST;
                            if (byte_ptr_reg == BYTE_LUX_LAST)
                            begin
                                byte_ptr_next = BYTE_FIRST;
                                phase_next    = PH_STB_RISE;
                            end
                            else
                            begin
                                byte_ptr_next = byte_ptr_reg - 4'd1;
                                phase_next    = PH_CLK_RISE;
                            end
                        end
                        else
                        begin
                            bit_ptr_next = bit_ptr_reg + 3'd1;
                            phase_next   = PH_CLK_RISE;
                        end
                    end
                    PH_STB_RISE:
                    begin
                        strobe_next = 1'b1;
                        phase_next  = PH_STB_FALL;
                    end
                    PH_STB_FALL:
                    begin
                        strobe_next  = 1'b0;
                        phase_next   = PH_CLK_RISE;
                        sending_next = 1'b0;
                        done         = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_CLK_RISE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_CLK_RISE;
            byte_ptr_reg <= BYTE_FIRST;
            bit_ptr_reg  <= BIT_FIRST;
            sending_reg  <= 1'b1;
            data_reg     <= 1'b0;
            clock_reg    <= 1'b0;
            strobe_reg   <= 1'b0;
            volt_reg     <= '{lead: SEG_BLANK, mid: SEG_BLANK, last: SEG_BLANK};
            lux_reg      <= '{lead: SEG_BLANK, mid: SEG_BLANK, last: SEG_BLANK};
        end
        else
        begin
            phase_reg    <= phase_next;
            byte_ptr_reg <= byte_ptr_next;
            bit_ptr_reg  <= bit_ptr_next;
            sending_reg  <= sending_next;
            data_reg     <= data_next;
            clock_reg    <= clock_next;
            strobe_reg   <= strobe_next;
            if (codes_valid)
            begin
                volt_reg <= volt_codes;
                lux_reg  <= lux_codes;
            end
        end
    end

    assign result.data_pin        = data_next;
    assign result.clock_pin       = clock_next;
    assign result.strobe_pin      = strobe_next;
    assign result.frame_done      = done;
    assign result.busy_res        = sending_next;
    assign result.refresh_ignored = ignored;

endmodule

// ----- sv/ssfs_outq.sv -----
// Two-entry result queue between the sequencer and the output channel.
module ssfs_outq
    import ssfs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    input  logic    pop,
    output logic    full,
    output logic    head_valid,
    output result_t head
);

    logic [1:0] count_reg;
    result_t    head_reg;
    result_t    tail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            unique case (count_reg)
                2'd0:
                begin
                    if (push)
                    begin
                        count_reg <= 2'd1;
                    end
                end
                2'd1:
                begin
                    if (push && !pop)
                    begin
                        count_reg <= 2'd2;
                    end
                    else if (!push && pop)
                    begin
                        count_reg <= 2'd0;
                    end
                end
                2'd2:
                begin
                    if (pop)
                    begin
                        count_reg <= 2'd1;
                    end
                end
                default:
                begin
                    count_reg <= 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (count_reg == 2'd0 || (count_reg == 2'd1 && pop))
        begin
            if (push)
            begin
                head_reg <= push_data;
            end
        end
        else if (count_reg == 2'd1)
        begin
            if (push)
            begin
                tail_reg <= push_data;
            end
        end
        else if (pop)
        begin
            head_reg <= tail_reg;
        end
    end

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = head_reg;

endmodule

// ----- bench/seven_segment_frame_shifter_top_tb.sv -----
// Testbench for the seven-segment frame shifter: random refresh/tick traffic against a predictor.
`timescale 1ns / 100ps

module seven_segment_frame_shifter_top_tb
    import ssfs_pkg::*;
();

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

    class frame_pin_scoreboard;
        result_t    pending_q[$];
        logic [7:0] frame[9];
        logic [7:0] digit_seg[10];
        logic [1:0] phase;
        logic [3:0] byte_ptr;
        logic [2:0] bit_ptr;
        logic       sending;
        logic       data_lvl;
        logic       clock_lvl;
        logic       strobe_lvl;
        int         failures;

        function new();
            digit_seg = '{8'h88, 8'hEE, 8'h94, 8'hC4, 8'hE2, 8'hC1, 8'h81, 8'hEC, 8'h80, 8'hC0};
            foreach (frame[i])
                frame[i] = SEG_BLANK;
            frame[BYTE_LED_GRP_A] = LED_GROUP_OFF;
            frame[BYTE_LED_GRP_B] = LED_GROUP_OFF;
            frame[BYTE_SINGLE]    = SINGLE_LEDS_OFF;
            phase      = PH_CLK_RISE;
            byte_ptr   = BYTE_FIRST;
            bit_ptr    = BIT_FIRST;
            sending    = 1'b1;
            data_lvl   = 1'b0;
            clock_lvl  = 1'b0;
            strobe_lvl = 1'b0;
            failures   = 0;
        endfunction

        function void draw_value(int v, logic [3:0] lead, logic [3:0] mid, logic [3:0] last);
            logic [7:0] a;
            logic [7:0] b;
            logic [7:0] c;
            int         whole;
            a = SEG_BLANK;
            b = SEG_BLANK;
            c = SEG_BLANK;
            if (v <= 999)
            begin
                c = digit_seg[v % 10];
                if (v >= 10)
                    b = digit_seg[(v / 10) % 10];
                if (v >= 100)
                    a = digit_seg[(v / 100) % 10];
            end
            else
            begin
                whole = v / 1000;
                c = digit_seg[(v % 1000) / 100];
                b = digit_seg[whole % 10] & DOT_CLEAR_MASK;
                if (whole / 10 != 0)
                    a = digit_seg[(whole / 10) % 10];
            end
            frame[lead] = a;
            frame[mid]  = b;
            frame[last] = c;
        endfunction

        function void note_input(logic cmd, logic [16:0] mv, logic [15:0] lx);
            result_t r;
            logic    done;
            logic    ignored;
            done    = 1'b0;
            ignored = 1'b0;
            if (cmd == CMD_REFRESH)
            begin
                if (sending)
                    ignored = 1'b1;
                else
                begin
                    draw_value(int'(mv), BYTE_VOLT_LEAD, BYTE_VOLT_MID, BYTE_VOLT_LAST);
                    draw_value(int'(lx), BYTE_LUX_LEAD, BYTE_LUX_MID, BYTE_LUX_LAST);
                    phase    = PH_CLK_RISE;
                    byte_ptr = BYTE_FIRST;
                    bit_ptr  = BIT_FIRST;
                    sending  = 1'b1;
                end
            end
            else if (sending)
            begin
                case (phase)
                    PH_CLK_RISE:
                    begin
                        data_lvl  = frame[byte_ptr][bit_ptr];
                        clock_lvl = 1'b1;
                        phase     = PH_CLK_FALL;
                    end
                    PH_CLK_FALL:
                    begin
                        clock_lvl = 1'b0;
                        phase     = PH_CLK_RISE;
                        if (bit_ptr == BIT_LAST)
                        begin
                            bit_ptr = BIT_FIRST;
                            if (byte_ptr == BYTE_LUX_LAST)
                            begin
                                byte_ptr = BYTE_FIRST;
                                phase    = PH_STB_RISE;
                            end
                            else
                                byte_ptr = byte_ptr - 4'd1;
                        end
                        else
                            bit_ptr = bit_ptr + 3'd1;
                    end
                    PH_STB_RISE:
                    begin
                        strobe_lvl = 1'b1;
                        phase      = PH_STB_FALL;
                    end
                    default:
                    begin
                        strobe_lvl = 1'b0;
                        phase      = PH_CLK_RISE;
                        sending    = 1'b0;
                        done       = 1'b1;
                    end
                endcase
            end
            r.data_pin        = data_lvl;
            r.clock_pin       = clock_lvl;
            r.strobe_pin      = strobe_lvl;
            r.frame_done      = done;
            r.busy_res        = sending;
            r.refresh_ignored = ignored;
            pending_q.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_q.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected result beat %b", $time, got);
                return;
            end
            want = pending_q.pop_front();
            if (got !== want)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch (data clk stb done busy ign) expected %b actual %b",
                             $time, want, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        command;
    logic [16:0] voltage_mv;
    logic [15:0] lux_value;
    logic        out_valid;
    logic        out_stall;
    logic        data_pin;
    logic        clock_pin;
    logic        strobe_pin;
    logic        frame_done;
    logic        busy_res;
    logic        refresh_ignored;

    frame_pin_scoreboard sb;
    idle_mode_t          idle_mode;
    int                  sent_items;

    seven_segment_frame_shifter_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .voltage_mv      (voltage_mv),
        .lux_value       (lux_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .data_pin        (data_pin),
        .clock_pin       (clock_pin),
        .strobe_pin      (strobe_pin),
        .frame_done      (frame_done),
        .busy_res        (busy_res),
        .refresh_ignored (refresh_ignored)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic bit src_gap();
        if (idle_mode == IDLE_SRC)
            return $urandom_range(99) < 46;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(99) < 11;
        return 1'b0;
    endfunction

    function automatic int pick_value(int maxv);
        int corner[13];
        int v;
        corner = '{0, 9, 10, 99, 100, 999, 1000, 9999, 10000, 65535, 99999, 100000, 131071};
        case ($urandom_range(6))
            0:       v = corner[$urandom_range(12)];
            1:       v = $urandom_range(9);
            2:       v = $urandom_range(99, 10);
            3:       v = $urandom_range(999, 100);
            4:       v = $urandom_range(9999, 1000);
            5:       v = $urandom_range(maxv, 10000);
            default: v = $urandom_range(maxv);
        endcase
        return (v > maxv) ? maxv : v;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_item(input logic cmd, input logic [16:0] mv, input logic [15:0] lx);
        while (src_gap())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        voltage_mv <= mv;
        lux_value  <= lx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(cmd, mv, lx);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic shift_frame(input int mv, input int lx);
        send_item(CMD_REFRESH, 17'(mv), 16'(lx));
        while (sb.sending)
        begin
            if ($urandom_range(99) < 3)
                send_item(CMD_REFRESH, 17'($urandom), 16'($urandom));
            else
                send_item(CMD_TICK, 17'($urandom), 16'($urandom));
        end
        repeat ($urandom_range(2))
            send_item(CMD_TICK, 17'($urandom), 16'($urandom));
    endtask

    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            case (idle_mode)
                IDLE_SNK:  out_stall <= ($urandom_range(99) < 46);
                IDLE_BOTH: out_stall <= ($urandom_range(99) < 11);
                default:   out_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.data_pin        = data_pin;
            got.clock_pin       = clock_pin;
            got.strobe_pin      = strobe_pin;
            got.frame_done      = frame_done;
            got.busy_res        = busy_res;
            got.refresh_ignored = refresh_ignored;
            sb.check_result(got);
        end
    end

    initial
    begin
        int frame_no;
        sb         = new();
        idle_mode  = IDLE_NONE;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        command    = CMD_REFRESH;
        voltage_mv = '0;
        lux_value  = '0;
        sent_items = 0;
        frame_no   = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // blank frame after reset: busy refreshes are dropped
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_REFRESH, 17'h1FFFF, 16'hFFFF);
        send_item(CMD_REFRESH, '0, '0);
        while (sb.sending)
            send_item(CMD_TICK, 17'($urandom), 16'($urandom));
        // idle ticks leave the pins alone
        send_item(CMD_TICK, 17'h1FFFF, 16'hFFFF);
        send_item(CMD_TICK, '0, '0);
        shift_frame(0, 0);
        drain_results();

        while (sent_items < 1380)
        begin
            idle_mode = idle_mode_t'(frame_no % 4);
            shift_frame(pick_value(131071), pick_value(65535));
            frame_no++;
            drain_results();
        end

        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (sb.failures == 0 && sb.pending_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
